// ===== src/mtdv_pkg.sv =====
// Shared types and constants for the MIDI track delta-time VLQ encoder.
package mtdv_pkg;

  localparam int unsigned TICK_BITS_DEF = 32;
  localparam int unsigned EVENT_TICK_W  = 32;
  localparam int unsigned VLQ_W         = 28;
  localparam int unsigned GROUP_W       = 7;
  localparam int unsigned RUN_MAX       = 5;
  localparam int unsigned RUN_LEN_W     = 3;

  localparam logic [VLQ_W-1:0] VLQ_CAP  = 28'hFFF_FFFF;
  localparam logic             VLQ_CONT = 1'b1;

  // action codes
  localparam logic ACT_BYTE   = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // end-of-track meta event
  localparam logic [7:0] EOT_B0 = 8'h00;
  localparam logic [7:0] EOT_B1 = 8'hFF;
  localparam logic [7:0] EOT_B2 = 8'h2F;
  localparam logic [7:0] EOT_B3 = 8'h00;

  typedef struct packed {
    logic                    action;
    logic                    starts_event;
    logic [EVENT_TICK_W-1:0] event_tick;
    logic [7:0]              data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  // bytes[0] goes out first
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_LEN_W-1:0]    len;
  } run_t;

endpackage

// ===== src/midi_track_delta_vlq_encoder_core.sv =====
// MIDI track body encoder: delta-time VLQ plus message bytes, end-of-track on finish.
// An accepted item's run is built combinationally, registered in the pending stage and
//   then moved into the serializing run register, whose bytes[0] drives the output.
// Throughput: one output byte per cycle while the output is not stalled; an item yields
//   1 byte (plain), 2 to 5 bytes (event start: VLQ delta then message byte) or 4 bytes
//   (finish), sent out one by one from the serializing run register.
// One pending item is held while the run register drains, so input is not stalled
//   just because an output byte waits. Reset (async, active low) empties both stages
//   and clears the stored previous tick to zero.
module midi_track_delta_vlq_encoder_core #(
  parameter int unsigned TICK_BITS = mtdv_pkg::TICK_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mtdv_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mtdv_pkg::out_t out_data_o
);

  // tick arithmetic never needs more bits than the event_tick field carries
  localparam int unsigned TickW = (TICK_BITS < mtdv_pkg::EVENT_TICK_W) ?
                                  TICK_BITS : mtdv_pkg::EVENT_TICK_W;

  logic [TickW-1:0] prev_tick_q, prev_tick_d;
  logic [TickW-1:0] next_tick;
  mtdv_pkg::run_t   new_run;

  // pending stage: one fully built run waiting for the serializer
  logic             pend_valid_q, pend_valid_d;
  mtdv_pkg::run_t   pend_run_q, pend_run_d;

  // serializer: bytes[0] is on the output, rem counts bytes still to go
  logic                                  run_valid_q, run_valid_d;
  logic [mtdv_pkg::RUN_MAX-1:0][7:0]     run_bytes_q, run_bytes_d;
  logic [mtdv_pkg::RUN_LEN_W-1:0]        run_rem_q, run_rem_d;

  logic in_take, out_take, run_done, run_free, pend_move;

  mtdv_run_build #(
    .TickW(TickW)
  ) u_build (
    .item_i      (in_data_i),
    .prev_tick_i (prev_tick_q),
    .run_o       (new_run),
    .next_tick_o (next_tick)
  );

  // handshake
  assign out_take   = run_valid_q && !out_stall_i;
  assign run_done   = out_take && (run_rem_q == 3'd1);
  assign run_free   = !run_valid_q || run_done;
  assign pend_move  = pend_valid_q && run_free;
  assign in_stall_o = pend_valid_q && !run_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // previous tick advances at accept time so back-to-back events see it
  assign prev_tick_d = in_take ? next_tick : prev_tick_q;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_run_d   = pend_run_q;
    if (in_take) begin
      pend_valid_d = 1'b1;
      pend_run_d   = new_run;
    end else if (pend_move) begin
      pend_valid_d = 1'b0;
    end
  end

  always_comb begin
    run_valid_d = run_valid_q;
    run_bytes_d = run_bytes_q;
    run_rem_d   = run_rem_q;
    if (pend_move) begin
      run_valid_d = 1'b1;
      run_bytes_d = pend_run_q.bytes;
      run_rem_d   = pend_run_q.len;
    end else if (run_done) begin
      run_valid_d = 1'b0;
    end else if (out_take) begin
      run_bytes_d = {8'h00, run_bytes_q[mtdv_pkg::RUN_MAX-1:1]};
      run_rem_d   = run_rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_tick_q  <= '0;
      pend_valid_q <= 1'b0;
      run_valid_q  <= 1'b0;
      run_rem_q    <= '0;
    end else begin
      prev_tick_q  <= prev_tick_d;
      pend_valid_q <= pend_valid_d;
      run_valid_q  <= run_valid_d;
      run_rem_q    <= run_rem_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    pend_run_q  <= pend_run_d;
    run_bytes_q <= run_bytes_d;
  end

  assign out_valid_o            = run_valid_q;
  assign out_data_o.out_byte    = run_bytes_q[0];
  assign out_data_o.last_of_run = (run_rem_q == 3'd1);

endmodule

// ===== src/mtdv_run_build.sv =====
// Builds the byte run (VLQ delta + message byte, or end-of-track) for one item.
module mtdv_run_build #(
  parameter int unsigned TickW = 32
) (
  input  mtdv_pkg::in_t     item_i,
  input  logic [TickW-1:0]  prev_tick_i,
  output mtdv_pkg::run_t    run_o,
  output logic [TickW-1:0]  next_tick_o
);

  logic [TickW-1:0]               tick;
  logic [TickW-1:0]               diff;
  logic                           over;
  logic [mtdv_pkg::VLQ_W-1:0]     dlt;
  logic [mtdv_pkg::GROUP_W-1:0]   g3, g2, g1, g0;

  assign tick = item_i.event_tick[TickW-1:0];

  always_comb begin
    diff = (tick > prev_tick_i) ? (tick - prev_tick_i) : '0;
    over = (diff >> mtdv_pkg::VLQ_W) != '0;
    dlt  = over ? mtdv_pkg::VLQ_CAP : diff[mtdv_pkg::VLQ_W-1:0];
    g3   = dlt[27:21];
    g2   = dlt[20:14];
    g1   = dlt[13:7];
    g0   = dlt[6:0];

    run_o       = '0;
    next_tick_o = prev_tick_i;

    if (item_i.action == mtdv_pkg::ACT_FINISH) begin
      run_o.bytes[0] = mtdv_pkg::EOT_B0;
      run_o.bytes[1] = mtdv_pkg::EOT_B1;
      run_o.bytes[2] = mtdv_pkg::EOT_B2;
      run_o.bytes[3] = mtdv_pkg::EOT_B3;
      run_o.len      = 3'd4;
      next_tick_o    = '0;
    end else if (item_i.starts_event) begin
      next_tick_o = tick;
      // shortest form: most significant nonzero group first
      priority if (g3 != '0) begin
        run_o.bytes[0] = {mtdv_pkg::VLQ_CONT, g3};
        run_o.bytes[1] = {mtdv_pkg::VLQ_CONT, g2};
        run_o.bytes[2] = {mtdv_pkg::VLQ_CONT, g1};
        run_o.bytes[3] = {1'b0, g0};
        run_o.bytes[4] = item_i.data_byte;
        run_o.len      = 3'd5;
      end else if (g2 != '0) begin
        run_o.bytes[0] = {mtdv_pkg::VLQ_CONT, g2};
        run_o.bytes[1] = {mtdv_pkg::VLQ_CONT, g1};
        run_o.bytes[2] = {1'b0, g0};
        run_o.bytes[3] = item_i.data_byte;
        run_o.len      = 3'd4;
      end else if (g1 != '0) begin
        run_o.bytes[0] = {mtdv_pkg::VLQ_CONT, g1};
        run_o.bytes[1] = {1'b0, g0};
        run_o.bytes[2] = item_i.data_byte;
        run_o.len      = 3'd3;
      end else begin
        run_o.bytes[0] = {1'b0, g0};
        run_o.bytes[1] = item_i.data_byte;
        run_o.len      = 3'd2;
      end
    end else begin
      run_o.bytes[0] = item_i.data_byte;
      run_o.len      = 3'd1;
    end
  end

endmodule

// ===== src/mtdv_checker.sv =====
// Port-level checker for the track encoder, bound to the top level.
module mtdv_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input mtdv_pkg::out_t out_data_o
);

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  // input only stalls while the serializer has bytes to send
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // an accepted item makes the output valid, with its own run or one still draining ahead of it
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("accepted item produced no output");

  // output only starts from an accepted item that went through the pending stage
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output appeared without an accepted item");

endmodule

bind midi_track_delta_vlq_encoder_core mtdv_checker u_mtdv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== dv/midi_track_delta_vlq_encoder_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the MIDI track delta-time VLQ encoder core.
module midi_track_delta_vlq_encoder_core_test;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 258;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  mtdv_pkg::in_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  mtdv_pkg::out_t out_data_o;

  midi_track_delta_vlq_encoder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Expected track bytes, oldest first, and the predictor's copy of the tick.
  mtdv_pkg::out_t expected_bytes[$];
  logic [31:0]    last_event_tick = '0;
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  bit             steady_run = 1'b0;   // no idling on either side while set
  logic [31:0]    track_tick = '0;     // stimulus-side tick of the track being built

  // Work out the byte run one accepted item causes and queue it.
  function automatic void predict_run(input mtdv_pkg::in_t it);
    logic [7:0]     run_bytes [mtdv_pkg::RUN_MAX];
    int             run_len;
    int             groups;
    logic [31:0]    delta;
    mtdv_pkg::out_t o;
    run_len = 0;
    if (it.action == mtdv_pkg::ACT_FINISH) begin
      run_bytes[0] = mtdv_pkg::EOT_B0;
      run_bytes[1] = mtdv_pkg::EOT_B1;
      run_bytes[2] = mtdv_pkg::EOT_B2;
      run_bytes[3] = mtdv_pkg::EOT_B3;
      run_len = 4;
      last_event_tick = '0;
    end else begin
      if (it.starts_event) begin
        // negative delta clamps to zero, oversized delta saturates at the cap
        delta = (it.event_tick > last_event_tick) ? it.event_tick - last_event_tick : '0;
        if (delta > {4'b0, mtdv_pkg::VLQ_CAP}) delta = {4'b0, mtdv_pkg::VLQ_CAP};
        groups = 1;
        while (groups < 4 && (delta >> (mtdv_pkg::GROUP_W * groups)) != 0) groups++;
        for (int g = groups - 1; g >= 0; g--) begin
          run_bytes[run_len] = {(g != 0) ? mtdv_pkg::VLQ_CONT : 1'b0,
                                delta[mtdv_pkg::GROUP_W*g +: 7]};
          run_len++;
        end
        last_event_tick = it.event_tick;
      end
      run_bytes[run_len] = it.data_byte;
      run_len++;
    end
    for (int b = 0; b < run_len; b++) begin
      o.out_byte    = run_bytes[b];
      o.last_of_run = (b == run_len - 1);
      expected_bytes.insert(expected_bytes.size(), o);
    end
  endfunction

  // Drive one item, with random idle gaps ahead of it, and predict on acceptance.
  task automatic send_item(input mtdv_pkg::in_t it);
    while (!steady_run && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_run(it);
  endtask

  task automatic send_byte(input logic [7:0] data);
    mtdv_pkg::in_t it;
    it = '{action: mtdv_pkg::ACT_BYTE, starts_event: 1'b0, event_tick: $urandom,
           data_byte: data};
    send_item(it);
  endtask

  task automatic send_event(input logic [31:0] tick, input logic [7:0] data);
    mtdv_pkg::in_t it;
    it = '{action: mtdv_pkg::ACT_BYTE, starts_event: 1'b1, event_tick: tick,
           data_byte: data};
    send_item(it);
  endtask

  // Finish ignores the other fields, so fill them with junk.
  task automatic send_finish();
    mtdv_pkg::in_t it;
    it = '{action: mtdv_pkg::ACT_FINISH, starts_event: 1'($urandom), event_tick: $urandom,
           data_byte: 8'($urandom)};
    send_item(it);
  endtask

  task automatic test_plain_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
  endtask

  // Deltas on each VLQ length boundary, then past the cap and at the top tick.
  task automatic test_vlq_lengths();
    send_event(32'h0000_0000, 8'h90);  // zero delta from reset
    send_event(32'h0000_007F, 8'h3C);  // largest one-byte delta
    send_event(32'h0000_00FF, 8'h40);  // 0x80, two bytes
    send_event(32'h0000_40FE, 8'h80);  // 0x3FFF
    send_event(32'h0000_80FE, 8'h45);  // 0x4000, three bytes
    send_event(32'h0020_80FD, 8'hB0);  // 0x1FFFFF
    send_event(32'h0040_80FD, 8'h07);  // 0x200000, four bytes
    send_event(32'h1040_80FC, 8'hC0);  // exactly the cap
    send_event(32'hFFFF_FFFF, 8'hFF);  // beyond the cap, saturates
  endtask

  task automatic test_backwards_tick();
    send_event(32'h0000_1000, 8'h90);  // still descending from the top tick
    send_event(32'h0000_0800, 8'h80);
    send_event(32'h0000_0900, 8'h00);  // measured from the smaller stored tick
  endtask

  task automatic test_finish();
    send_event(32'h0000_5000, 8'h91);
    send_byte(8'h24);
    send_finish();
    send_event(32'h0000_0005, 8'h92);  // delta counted from zero again
    send_finish();
    send_finish();                     // back-to-back finish
  endtask

  // Mostly well-formed tracks with random deltas; some noise items mixed in.
  task automatic test_random_tracks();
    int unsigned   sent;
    int unsigned   pick;
    int unsigned   trail;
    logic [31:0]   delta;
    mtdv_pkg::in_t it;
    sent = 0;
    track_tick = '0;
    while (sent < RANDOM_ITEMS) begin
      steady_run = (sent >= 100 && sent < 170);
      pick = $urandom_range(99);
      if (pick < 8) begin
        it = '{action: 1'($urandom), starts_event: 1'($urandom), event_tick: $urandom,
               data_byte: 8'($urandom)};
        send_item(it);
        if (it.action == mtdv_pkg::ACT_FINISH) track_tick = '0;
        else if (it.starts_event) track_tick = it.event_tick;
        sent++;
      end else if (pick < 15) begin
        send_finish();
        track_tick = '0;
        sent++;
      end else begin
        case ($urandom_range(7))
          0: delta = '0;
          1: delta = $urandom_range(127);
          2: delta = $urandom_range(16383, 128);
          3: delta = $urandom_range(32'h1F_FFFF, 16384);
          4: delta = $urandom_range(32'h0FFF_FFFF, 32'h20_0000);
          5: delta = $urandom_range(32'hFFFF_FFFF, 32'h1000_0000);
          6: delta = -$urandom_range(32'h0FFF_FFFF);  // tick steps back
          default: delta = $urandom_range(600);
        endcase
        track_tick = track_tick + delta;
        send_event(track_tick, 8'($urandom));
        sent++;
        trail = $urandom_range(2);
        for (int t = 0; t < trail; t++) begin
          send_byte(8'($urandom));
          sent++;
        end
      end
    end
    steady_run = 1'b0;
  endtask

  // Receiver stall, random except during the steady stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !steady_run && ($urandom_range(99) < 17);
  end

  // Compare every accepted byte against the oldest expectation.
  always @(posedge clk_i) begin
    mtdv_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected byte %02h last=%0b", out_data_o.out_byte,
                   out_data_o.last_of_run);
      end else begin
        want = expected_bytes.pop_front();
        if (out_data_o.out_byte !== want.out_byte ||
            out_data_o.last_of_run !== want.last_of_run) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("byte mismatch: expected %02h last=%0b, got %02h last=%0b",
                     want.out_byte, want.last_of_run, out_data_o.out_byte,
                     out_data_o.last_of_run);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_bytes();
    test_vlq_lengths();
    test_backwards_tick();
    test_finish();
    test_random_tracks();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mtdv_pkg.sv
src/mtdv_run_build.sv
src/midi_track_delta_vlq_encoder_core.sv
src/mtdv_checker.sv
dv/midi_track_delta_vlq_encoder_core_test.sv
